### rtl/trul_pkg.sv
package trul_pkg;

  // Default coordinate width and queue depth between front and back.
  localparam int COORD_W_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  // Width of the vertex position field.
  localparam int VIDX_W = 3;

  // Outline kind decided by the front and carried out by the back.
  typedef enum logic [2:0] {
    KIND_FAIL,
    KIND_BOX,
    KIND_HPAIR,
    KIND_VPAIR,
    KIND_TLBR,
    KIND_BLTR
  } kind_e;

  localparam int KIND_W = $bits(kind_e);

  // Position of the final vertex of each outline kind.
  function automatic logic [VIDX_W-1:0] last_index(kind_e kind);
    logic [VIDX_W-1:0] idx;
    unique case (kind) inside
      KIND_BOX:                idx = VIDX_W'(3);
      KIND_HPAIR, KIND_VPAIR:  idx = VIDX_W'(5);
      KIND_TLBR, KIND_BLTR:    idx = VIDX_W'(7);
      default:                 idx = VIDX_W'(0);
    endcase
    return idx;
  endfunction

endpackage

### rtl/trul_in_if.sv
interface trul_in_if import trul_pkg::*; #(
  parameter int COORD_W = COORD_W_DEF
) ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] a_left;
  logic signed [COORD_W-1:0] a_top;
  logic signed [COORD_W-1:0] a_right;
  logic signed [COORD_W-1:0] a_bottom;
  logic signed [COORD_W-1:0] b_left;
  logic signed [COORD_W-1:0] b_top;
  logic signed [COORD_W-1:0] b_right;
  logic signed [COORD_W-1:0] b_bottom;

  modport source (
    output valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    input  ready
  );

  modport sink (
    input  valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    output ready
  );

endinterface

### rtl/trul_out_if.sv
interface trul_out_if import trul_pkg::*; #(
  parameter int COORD_W = COORD_W_DEF
) ();

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [VIDX_W-1:0]         vertex_index;
  logic                      last;

  modport source (
    output valid, found, vertex_x, vertex_y, vertex_index, last,
    input  ready
  );

  modport sink (
    input  valid, found, vertex_x, vertex_y, vertex_index, last,
    output ready
  );

endinterface

### rtl/two_rectangle_union_outline.sv
// Channel   Dir   Transfer carries
// in_i      in    one rectangle pair: a_left..a_bottom, b_left..b_bottom
// out_o     out   one outline vertex: found, vertex_x, vertex_y, vertex_index, last
//
// Every pair passes a six-stage area pipeline that can take one pair per cycle unless its last stage is held.
// The back end sends one vertex per cycle while the output is not held, so a pair costs 4, 6 or 8 vertices
// for an outline and a single result for a failure; that vertex port sets the rate.
// A pair reaches its first vertex through the front stages, the queue and the output register.
// Reset clears only valid bits, queue pointers and fill count, and the vertex counter.
// A held output fills the two-entry queue, and then the pipeline and input stall.
module two_rectangle_union_outline import trul_pkg::*; #(
  parameter int COORD_W = COORD_W_DEF,
  parameter int QDEPTH  = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trul_in_if.sink    in_i,
  trul_out_if.source out_o
);

  localparam int ENTRY_W = KIND_W + 12 * COORD_W;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  // Front: area test and outline classification.
  trul_front #(
    .COORD_W (COORD_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue between classification and vertex generation.
  trul_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QDEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: vertex sequencer with output register.
  trul_back #(
    .COORD_W (COORD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

  // The input stalls only when a classified pair is waiting on a full queue.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (push_valid && !push_ready))
    else $error("input stalled without a full queue");

  // An entry leaves the queue only while one is there.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready |-> pop_valid)
    else $error("queue popped while empty");

  // A failure is a single zero result.
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |->
      (out_o.last && (out_o.vertex_index == '0) && (out_o.vertex_x == '0) &&
       (out_o.vertex_y == '0)))
    else $error("failure result malformed");

  // An outline always ends on its fourth, sixth or eighth vertex.
  a_outline_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found && out_o.last) |->
      ((out_o.vertex_index == last_index(KIND_BOX)) ||
       (out_o.vertex_index == last_index(KIND_HPAIR)) ||
       (out_o.vertex_index == last_index(KIND_TLBR))))
    else $error("outline ended at a wrong vertex");

endmodule

### rtl/trul_fifo.sv
module trul_fifo import trul_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update, with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/trul_front.sv
module trul_front import trul_pkg::*; #(
  parameter  int COORD_W = COORD_W_DEF,
  localparam int ENTRY_W = KIND_W + 12 * COORD_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  trul_in_if.sink            in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output logic [ENTRY_W-1:0] push_data_o
);

  // Operands are split into halves so each partial product stays narrow.
  localparam int H  = (COORD_W + 1) / 2;
  localparam int PW = 2 * H;
  localparam int AW = 4 * H;
  localparam int SW = AW + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    rect_t a;
    rect_t b;
    rect_t u;
    kind_e pass_kind;
    logic  pass_swap;
    kind_e fail_kind;
    logic  fail_swap;
  } geom_t;

  typedef struct packed {
    kind_e kind;
    rect_t p;
    rect_t q;
    rect_t u;
  } entry_t;

  function automatic logic is_tlbr(rect_t x, rect_t y);
    return (x.l < y.l) && (x.t < y.t) && (x.r < y.r) && (x.b < y.b);
  endfunction

  function automatic logic is_bltr(rect_t x, rect_t y);
    return (x.l < y.l) && (x.t > y.t) && (x.r < y.r) && (x.b > y.b);
  endfunction

  logic [6:1]        vld_q;
  logic              advance;
  rect_t             a_q, b_q;
  rect_t             in_a, in_b;
  geom_t             geom_d;
  geom_t             geom_q [2:6];
  logic [COORD_W-1:0] op_d [4][2];
  logic [COORD_W-1:0] op_q [4][2];
  logic [PW-1:0]     pp_d [4][4];
  logic [PW-1:0]     pp_q [4][4];
  logic [AW-1:0]     cat_d [4];
  logic [AW-1:0]     cat_q [4];
  logic [PW:0]       mid_d [4];
  logic [PW:0]       mid_q [4];
  logic [AW-1:0]     area_d [4];
  logic [AW-1:0]     area_q [4];
  logic [SW-1:0]     lhs_q, rhs_q;
  entry_t            entry;

  // The whole pipeline moves together unless the last stage is held.
  assign advance    = !vld_q[6] || push_ready_i;
  assign in_i.ready = advance;

  always_comb begin
    in_a = '{l: in_i.a_left, t: in_i.a_top, r: in_i.a_right, b: in_i.a_bottom};
    in_b = '{l: in_i.b_left, t: in_i.b_top, r: in_i.b_right, b: in_i.b_bottom};
  end

  // Stage 1 to 2: bounding box, intersection, side lengths and shape tests.
  always_comb begin
    rect_t             rects [4];
    rect_t             isect;
    logic [COORD_W:0]  dw, dh;
    logic              overlap;
    logic              hpair, vpair;

    geom_d.a = a_q;
    geom_d.b = b_q;
    geom_d.u.l = (a_q.l < b_q.l) ? a_q.l : b_q.l;
    geom_d.u.t = (a_q.t < b_q.t) ? a_q.t : b_q.t;
    geom_d.u.r = (a_q.r > b_q.r) ? a_q.r : b_q.r;
    geom_d.u.b = (a_q.b > b_q.b) ? a_q.b : b_q.b;
    isect.l = (a_q.l > b_q.l) ? a_q.l : b_q.l;
    isect.t = (a_q.t > b_q.t) ? a_q.t : b_q.t;
    isect.r = (a_q.r < b_q.r) ? a_q.r : b_q.r;
    isect.b = (a_q.b < b_q.b) ? a_q.b : b_q.b;

    rects[0] = a_q;
    rects[1] = b_q;
    rects[2] = geom_d.u;
    rects[3] = isect;
    for (int k = 0; k < 4; k++) begin
      dw = {rects[k].r[COORD_W-1], rects[k].r} - {rects[k].l[COORD_W-1], rects[k].l};
      dh = {rects[k].b[COORD_W-1], rects[k].b} - {rects[k].t[COORD_W-1], rects[k].t};
      // An empty rectangle contributes zero area.
      if ((rects[k].r > rects[k].l) && (rects[k].b > rects[k].t)) begin
        op_d[k][0] = dw[COORD_W-1:0];
        op_d[k][1] = dh[COORD_W-1:0];
      end else begin
        op_d[k][0] = '0;
        op_d[k][1] = '0;
      end
    end

    // Outline used when the union turns out to be a rectangle.
    hpair = (a_q.t == b_q.t) && (a_q.b == b_q.b) && ((a_q.r == b_q.l) || (b_q.r == a_q.l));
    vpair = (a_q.l == b_q.l) && (a_q.r == b_q.r) && ((a_q.b == b_q.t) || (b_q.b == a_q.t));
    if (hpair) begin
      geom_d.pass_kind = KIND_HPAIR;
      geom_d.pass_swap = !(a_q.l < b_q.l);
    end else if (vpair) begin
      geom_d.pass_kind = KIND_VPAIR;
      geom_d.pass_swap = !(a_q.t < b_q.t);
    end else begin
      geom_d.pass_kind = KIND_BOX;
      geom_d.pass_swap = 1'b0;
    end

    // Staircase outline, only for strictly overlapping pairs.
    overlap = (isect.l < isect.r) && (isect.t < isect.b);
    geom_d.fail_kind = KIND_FAIL;
    geom_d.fail_swap = 1'b0;
    if (overlap) begin
      if (is_tlbr(a_q, b_q)) begin
        geom_d.fail_kind = KIND_TLBR;
      end else if (is_tlbr(b_q, a_q)) begin
        geom_d.fail_kind = KIND_TLBR;
        geom_d.fail_swap = 1'b1;
      end else if (is_bltr(a_q, b_q)) begin
        geom_d.fail_kind = KIND_BLTR;
      end else if (is_bltr(b_q, a_q)) begin
        geom_d.fail_kind = KIND_BLTR;
        geom_d.fail_swap = 1'b1;
      end
    end
  end

  // Stage 2 to 3: four half-width partial products per area.
  always_comb begin
    logic [PW-1:0] ew, eh;
    for (int k = 0; k < 4; k++) begin
      ew = PW'(op_q[k][0]);
      eh = PW'(op_q[k][1]);
      pp_d[k][0] = PW'(ew[H-1:0])  * PW'(eh[H-1:0]);
      pp_d[k][1] = PW'(ew[H-1:0])  * PW'(eh[PW-1:H]);
      pp_d[k][2] = PW'(ew[PW-1:H]) * PW'(eh[H-1:0]);
      pp_d[k][3] = PW'(ew[PW-1:H]) * PW'(eh[PW-1:H]);
    end
  end

  // Stage 3 to 4 and 4 to 5: combine partial products into exact areas.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cat_d[k]  = {pp_q[k][3], pp_q[k][0]};
      mid_d[k]  = (PW + 1)'(pp_q[k][1]) + (PW + 1)'(pp_q[k][2]);
      area_d[k] = cat_q[k] + (AW'(mid_q[k]) << H);
    end
  end

  // Stage 6: area equality picks the outline kind and rectangle order.
  always_comb begin
    logic  pass;
    logic  swap;
    geom_t g;
    g    = geom_q[6];
    pass = (lhs_q == rhs_q);
    swap = pass ? g.pass_swap : g.fail_swap;
    entry.kind = pass ? g.pass_kind : g.fail_kind;
    entry.p    = swap ? g.b : g.a;
    entry.q    = swap ? g.a : g.b;
    entry.u    = g.u;
  end

  assign push_valid_o = vld_q[6];
  assign push_data_o  = ENTRY_W'(entry);

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[5:1], in_i.valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_q        <= in_a;
      b_q        <= in_b;
      geom_q[2]  <= geom_d;
      for (int s = 3; s <= 6; s++) begin
        geom_q[s] <= geom_q[s-1];
      end
      op_q   <= op_d;
      pp_q   <= pp_d;
      cat_q  <= cat_d;
      mid_q  <= mid_d;
      area_q <= area_d;
      lhs_q  <= SW'(area_q[0]) + SW'(area_q[1]);
      rhs_q  <= SW'(area_q[2]) + SW'(area_q[3]);
    end
  end

endmodule

### rtl/trul_back.sv
module trul_back import trul_pkg::*; #(
  parameter  int COORD_W = COORD_W_DEF,
  localparam int ENTRY_W = KIND_W + 12 * COORD_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  logic [ENTRY_W-1:0] pop_data_i,
  trul_out_if.source         out_o
);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    kind_e kind;
    rect_t p;
    rect_t q;
    rect_t u;
  } entry_t;

  entry_t            head;
  logic [VIDX_W-1:0] idx_q, idx_d;
  logic              vtx_last;
  logic              load;
  logic              take;
  coord_t            vx, vy;
  logic              out_vld_q;
  logic              found_q;
  coord_t            x_q, y_q;
  logic [VIDX_W-1:0] vidx_q;
  logic              last_q;

  assign head     = entry_t'(pop_data_i);
  assign vtx_last = (idx_q == last_index(head.kind));

  // The output register takes a new vertex whenever it is empty or drained.
  assign load        = !out_vld_q || out_o.ready;
  assign take        = pop_valid_i && load;
  assign pop_ready_o = take && vtx_last;
  assign idx_d       = take ? (vtx_last ? '0 : idx_q + VIDX_W'(1)) : idx_q;

  // Vertex coordinates for the current position of the outline.
  always_comb begin
    rect_t p, q, u;
    p  = head.p;
    q  = head.q;
    u  = head.u;
    vx = '0;
    vy = '0;
    unique case (head.kind)
      KIND_BOX: begin
        case (idx_q)
          VIDX_W'(0): begin vx = u.r; vy = u.b; end
          VIDX_W'(1): begin vx = u.l; vy = u.b; end
          VIDX_W'(2): begin vx = u.l; vy = u.t; end
          default:    begin vx = u.r; vy = u.t; end
        endcase
      end
      KIND_HPAIR: begin
        case (idx_q)
          VIDX_W'(0): begin vx = q.l; vy = u.t; end
          VIDX_W'(1): begin vx = u.r; vy = u.t; end
          VIDX_W'(2): begin vx = u.r; vy = u.b; end
          VIDX_W'(3): begin vx = q.l; vy = u.b; end
          VIDX_W'(4): begin vx = p.l; vy = u.b; end
          default:    begin vx = p.l; vy = u.t; end
        endcase
      end
      KIND_VPAIR: begin
        case (idx_q)
          VIDX_W'(0): begin vx = u.r; vy = u.b; end
          VIDX_W'(1): begin vx = u.l; vy = u.b; end
          VIDX_W'(2): begin vx = u.l; vy = q.t; end
          VIDX_W'(3): begin vx = u.l; vy = p.t; end
          VIDX_W'(4): begin vx = u.r; vy = p.t; end
          default:    begin vx = u.r; vy = q.t; end
        endcase
      end
      KIND_TLBR: begin
        case (idx_q)
          VIDX_W'(0): begin vx = p.r; vy = q.t; end
          VIDX_W'(1): begin vx = q.r; vy = q.t; end
          VIDX_W'(2): begin vx = q.r; vy = q.b; end
          VIDX_W'(3): begin vx = q.l; vy = q.b; end
          VIDX_W'(4): begin vx = q.l; vy = p.b; end
          VIDX_W'(5): begin vx = p.l; vy = p.b; end
          VIDX_W'(6): begin vx = p.l; vy = p.t; end
          default:    begin vx = p.r; vy = p.t; end
        endcase
      end
      KIND_BLTR: begin
        case (idx_q)
          VIDX_W'(0): begin vx = q.r; vy = q.b; end
          VIDX_W'(1): begin vx = p.r; vy = q.b; end
          VIDX_W'(2): begin vx = p.r; vy = p.b; end
          VIDX_W'(3): begin vx = p.l; vy = p.b; end
          VIDX_W'(4): begin vx = p.l; vy = p.t; end
          VIDX_W'(5): begin vx = q.l; vy = p.t; end
          VIDX_W'(6): begin vx = q.l; vy = q.t; end
          default:    begin vx = q.r; vy = q.t; end
        endcase
      end
      default: begin
        vx = '0;
        vy = '0;
      end
    endcase
  end

  // Control state: vertex counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_vld_q <= pop_valid_i;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      found_q <= (head.kind != KIND_FAIL);
      x_q     <= vx;
      y_q     <= vy;
      vidx_q  <= idx_q;
      last_q  <= vtx_last;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.found        = found_q;
  assign out_o.vertex_x     = x_q;
  assign out_o.vertex_y     = y_q;
  assign out_o.vertex_index = vidx_q;
  assign out_o.last         = last_q;

endmodule

### bench/testbench.sv
module testbench;
  import trul_pkg::*;

  localparam int COORD_W = COORD_W_DEF;
  localparam int CMIN = 32'sh8000_0000;
  localparam int CMAX = 32'sh7fff_ffff;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PAIRS = 160;

  // One rectangle pair as it crosses the input channel.
  typedef struct {
    logic signed [COORD_W-1:0] a_left, a_top, a_right, a_bottom;
    logic signed [COORD_W-1:0] b_left, b_top, b_right, b_bottom;
  } coord_pair_t;

  // One outline vertex as it crosses the output channel.
  typedef struct {
    logic                      found;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [VIDX_W-1:0]         idx;
    logic                      last;
  } vertex_t;

  // Rectangle with edges widened so that no comparison can overflow.
  typedef struct {
    longint l, t, r, b;
  } box_t;

  // Computes the outline of each accepted pair and checks the vertices in order.
  class outline_scoreboard;
    vertex_t expected_q[$];
    int      errors = 0;

    function longint lmin(longint p, longint q);
      return (p < q) ? p : q;
    endfunction

    function longint lmax(longint p, longint q);
      return (p > q) ? p : q;
    endfunction

    // Exact area; an inverted or flat rectangle counts as empty.
    function logic [127:0] box_area(box_t q);
      logic [127:0] w, h;
      if (q.r <= q.l || q.b <= q.t) return '0;
      w = 128'(q.r - q.l);
      h = 128'(q.b - q.t);
      return w * h;
    endfunction

    // Staircase with a at the top left and c at the bottom right.
    function bit falls_right(box_t a, box_t c, output longint px[8], output longint py[8]);
      px = '{a.r, c.r, c.r, c.l, c.l, a.l, a.l, a.r};
      py = '{c.t, c.t, c.b, c.b, a.b, a.b, a.t, a.t};
      return a.l < c.l && a.t < c.t && a.r < c.r && a.b < c.b;
    endfunction

    // Staircase with a at the bottom left and c at the top right.
    function bit rises_right(box_t a, box_t c, output longint px[8], output longint py[8]);
      px = '{c.r, a.r, a.r, a.l, a.l, c.l, c.l, c.r};
      py = '{c.b, c.b, a.b, a.b, a.t, a.t, c.t, c.t};
      return a.l < c.l && a.t > c.t && a.r < c.r && a.b > c.b;
    endfunction

    function void note_pair(coord_pair_t p);
      box_t    a, b, u, x, lo, hi;
      longint  px[8], py[8];
      int      n;
      vertex_t v;
      a = '{longint'(p.a_left), longint'(p.a_top),
            longint'(p.a_right), longint'(p.a_bottom)};
      b = '{longint'(p.b_left), longint'(p.b_top),
            longint'(p.b_right), longint'(p.b_bottom)};
      u = '{lmin(a.l, b.l), lmin(a.t, b.t), lmax(a.r, b.r), lmax(a.b, b.b)};
      x = '{lmax(a.l, b.l), lmax(a.t, b.t), lmin(a.r, b.r), lmin(a.b, b.b)};
      n = 0;
      if (box_area(a) + box_area(b) == box_area(u) + box_area(x)) begin
        if (a.t == b.t && a.b == b.b && (a.r == b.l || b.r == a.l)) begin
          // Side by side with a shared vertical edge.
          lo = (a.l < b.l) ? a : b;
          hi = (a.l < b.l) ? b : a;
          px = '{hi.l, u.r, u.r, hi.l, lo.l, lo.l, 0, 0};
          py = '{u.t, u.t, u.b, u.b, u.b, u.t, 0, 0};
          n = 6;
        end else if (a.l == b.l && a.r == b.r && (a.b == b.t || b.b == a.t)) begin
          // Stacked with a shared horizontal edge.
          lo = (a.t < b.t) ? a : b;
          hi = (a.t < b.t) ? b : a;
          px = '{u.r, u.l, u.l, u.l, u.r, u.r, 0, 0};
          py = '{u.b, u.b, hi.t, lo.t, lo.t, hi.t, 0, 0};
          n = 6;
        end else begin
          px = '{u.r, u.l, u.l, u.r, 0, 0, 0, 0};
          py = '{u.b, u.b, u.t, u.t, 0, 0, 0, 0};
          n = 4;
        end
      end else if (x.l < x.r && x.t < x.b) begin
        // Strict overlap: try the four staircase arrangements in turn.
        if (falls_right(a, b, px, py)) n = 8;
        else if (falls_right(b, a, px, py)) n = 8;
        else if (rises_right(a, b, px, py)) n = 8;
        else if (rises_right(b, a, px, py)) n = 8;
      end
      if (n == 0) begin
        v = '{found: 1'b0, x: '0, y: '0, idx: '0, last: 1'b1};
        expected_q.push_back(v);
      end
      for (int k = 0; k < n; k++) begin
        v.found = 1'b1;
        v.x     = COORD_W'(px[k]);
        v.y     = COORD_W'(py[k]);
        v.idx   = VIDX_W'(k);
        v.last  = (k == n - 1);
        expected_q.push_back(v);
      end
    endfunction

    function void check_vertex(logic found, logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y, logic [VIDX_W-1:0] idx,
                               logic last);
      vertex_t want;
      if (expected_q.size() == 0) begin
        $error("vertex with no outline pending: x=%0d y=%0d index=%0d", x, y, idx);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (x !== want.x) begin
        $error("vertex_x: expected %0d, got %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("vertex_y: expected %0d, got %0d", want.y, y);
        errors++;
      end
      if (idx !== want.idx) begin
        $error("vertex_index: expected %0d, got %0d", want.idx, idx);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  bit   in_gaps = 1'b1;
  bit   out_gaps = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  outline_scoreboard sb = new();

  trul_in_if  #(.COORD_W(COORD_W)) in_ch ();
  trul_out_if #(.COORD_W(COORD_W)) out_ch ();

  two_rectangle_union_outline #(.COORD_W(COORD_W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Output backpressure comes in random bursts while enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rst_ni && out_gaps && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 10);
    end else begin
      out_ch.ready <= rst_ni;
    end
  end

  // Check every vertex transfer and stop the run if the block goes quiet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_vertex(out_ch.found, out_ch.vertex_x, out_ch.vertex_y,
                        out_ch.vertex_index, out_ch.last);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic coord_pair_t pair_of(int al, int at, int ar, int ab,
                                          int bl, int bt, int br, int bb);
    coord_pair_t p;
    p = '{al, at, ar, ab, bl, bt, br, bb};
    return p;
  endfunction

  function automatic int rand_origin();
    return $signed($urandom_range(0, 1 << 30)) - (1 << 29);
  endfunction

  function automatic int rand_span();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 8);
    return $urandom_range(1, 1 << 20);
  endfunction

  // Mostly well-formed pairs of each outline kind, plus noise and near misses.
  function automatic coord_pair_t random_pair();
    coord_pair_t p, q;
    int          l, t, w, h, d1, d2;
    l  = rand_origin();
    t  = rand_origin();
    w  = rand_span() + 1;
    h  = rand_span() + 1;
    d1 = $urandom_range(1, w - 1);
    d2 = $urandom_range(1, h - 1);
    case ($urandom_range(0, 9))
      0, 1: p = pair_of($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
      2: p = pair_of(l, t, l + w, t + h, l + w, t, l + w + rand_span(), t + h);
      3: p = pair_of(l, t, l + w, t + h, l, t + h, l + w, t + h + rand_span());
      4: p = pair_of(l, t, l + w, t + h, l + d1, t + d2,
                     l + d1 + $urandom_range(0, w - d1), t + d2 + $urandom_range(0, h - d2));
      5, 6: p = pair_of(l, t, l + w, t + h, l + d1, t + d2,
                        l + w + rand_span(), t + h + rand_span());
      7: p = pair_of(l, t, l + w, t + h, l + d1, t - rand_span(),
                     l + w + rand_span(), t + d2);
      8: p = pair_of($urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                     $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                     $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                     $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6);
      default: p = pair_of(l, t, l + w, t + h, l + d1, t + d2, l + w, t + h + rand_span());
    endcase
    if ($urandom_range(0, 1) == 1) begin
      q = p;
      p = '{q.b_left, q.b_top, q.b_right, q.b_bottom, q.a_left, q.a_top, q.a_right, q.a_bottom};
    end
    return p;
  endfunction

  // Present one pair, after an optional idle burst, and wait for its transfer.
  task automatic send_pair(coord_pair_t p);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.a_left   <= p.a_left;
    in_ch.a_top    <= p.a_top;
    in_ch.a_right  <= p.a_right;
    in_ch.a_bottom <= p.a_bottom;
    in_ch.b_left   <= p.b_left;
    in_ch.b_top    <= p.b_top;
    in_ch.b_right  <= p.b_right;
    in_ch.b_bottom <= p.b_bottom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_pair(p);
  endtask

  initial begin
    coord_pair_t plan[$];
    in_ch.valid    <= 1'b0;
    in_ch.a_left   <= '0;
    in_ch.a_top    <= '0;
    in_ch.a_right  <= '0;
    in_ch.a_bottom <= '0;
    in_ch.b_left   <= '0;
    in_ch.b_top    <= '0;
    in_ch.b_right  <= '0;
    in_ch.b_bottom <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both empty at the extremes, full-range boxes and shared edges.
    plan.push_back(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    plan.push_back(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    plan.push_back(pair_of(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    plan.push_back(pair_of(CMIN, CMIN, 0, CMAX, 0, CMIN, CMAX, CMAX));
    plan.push_back(pair_of(10, 0, 20, 5, 0, 0, 10, 5));
    plan.push_back(pair_of(0, 0, 4, 3, 0, 3, 4, 9));
    plan.push_back(pair_of(0, 3, 4, 9, 0, 0, 4, 3));
    plan.push_back(pair_of(CMIN, CMIN, CMAX, 0, CMIN, 0, CMAX, CMAX));
    // Containment, partial overlap of equal height, and an empty one inside.
    plan.push_back(pair_of(0, 0, 10, 10, 2, 2, 5, 5));
    plan.push_back(pair_of(0, 0, 10, 5, 6, 0, 15, 5));
    plan.push_back(pair_of(1, 1, 1, 2, 0, 0, 4, 4));
    // Staircases in both arrangements and both orders.
    plan.push_back(pair_of(0, 0, 10, 10, 5, 5, 15, 15));
    plan.push_back(pair_of(5, 5, 15, 15, 0, 0, 10, 10));
    plan.push_back(pair_of(0, 5, 10, 15, 5, 0, 15, 10));
    plan.push_back(pair_of(5, 0, 15, 10, 0, 5, 10, 15));
    plan.push_back(pair_of(CMIN, CMIN, 0, 0, -100, -100, CMAX, CMAX));
    // Pairs that end in failure: apart, crossed, corner touch, L shape, shared top.
    plan.push_back(pair_of(0, 0, 1, 1, 5, 5, 6, 6));
    plan.push_back(pair_of(0, 4, 12, 8, 4, 0, 8, 12));
    plan.push_back(pair_of(0, 0, 5, 5, 5, 5, 10, 10));
    plan.push_back(pair_of(0, 0, 5, 5, 5, 0, 10, 3));
    plan.push_back(pair_of(0, 0, 10, 10, 5, 0, 15, 15));
    // Inverted coordinates on both sides.
    plan.push_back(pair_of(10, 10, 0, 0, 10, 10, 0, 0));
    foreach (plan[k]) send_pair(plan[k]);

    // Hold the input until every outline so far has come out.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);

    // Random pairs with idling on and off; the last stretch runs without any.
    for (int k = 0; k < RANDOM_PAIRS; k++) begin
      in_gaps  = (k < 50) || (k >= 80 && k < 120);
      out_gaps = in_gaps;
      send_pair(random_pair());
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/trul_pkg.sv
rtl/trul_in_if.sv
rtl/trul_out_if.sv
rtl/trul_fifo.sv
rtl/trul_front.sv
rtl/trul_back.sv
rtl/two_rectangle_union_outline.sv
bench/testbench.sv
